FILE: src/bcli_pkg.sv
`default_nettype none
package bcli_pkg;

  // Width of the averaged ADC samples and of the voltage thresholds
  localparam int SAMPLE_BITS = 12;
  // Compare width for samples against the fixed grade breakpoints
  localparam int CMP_W = 16;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [6:0] HOLD_MAX = 7'd100;
  localparam logic [5:0] PHASE_LAST = 6'd50;
  localparam logic [5:0] PHASE_INPUT_END = 6'd18;
  localparam logic [5:0] PHASE_BAT_FIRST = 6'd23;
  localparam logic [5:0] PHASE_BAT_END = 6'd45;
  localparam logic [2:0] STEP_TOP = 3'd4;

  // Battery grade breakpoints with hysteresis bands
  localparam logic [CMP_W-1:0] BAT_G1_MAX = 16'd1003;
  localparam logic [CMP_W-1:0] BAT_G2_HYS = 16'd1010;
  localparam logic [CMP_W-1:0] BAT_G2_MAX = 16'd1050;
  localparam logic [CMP_W-1:0] BAT_G3_HYS = 16'd1055;
  localparam logic [CMP_W-1:0] BAT_G3_MAX = 16'd1096;
  localparam logic [CMP_W-1:0] BAT_G4_HYS = 16'd1100;
  localparam logic [CMP_W-1:0] BAT_G4_MAX = 16'd1140;
  localparam logic [CMP_W-1:0] BAT_G5_MIN = 16'd1150;

  localparam logic [SAMPLE_BITS-1:0] RST_CHARGE_ON = SAMPLE_BITS'(1974);
  localparam logic [SAMPLE_BITS-1:0] RST_CHARGE_OFF = SAMPLE_BITS'(1900);
  localparam logic [9:0] RST_LED_ON = 10'd500;
  localparam logic [7:0] RST_SLEEP = 8'd200;
  localparam logic [5:0] RST_ANIM = 6'd35;
  localparam logic [6:0] RST_CLICK_MIN = 7'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARGE_ON  = 3'd0,
    CFG_CHARGE_OFF = 3'd1,
    CFG_LED_ON     = 3'd2,
    CFG_SLEEP      = 3'd3,
    CFG_ANIM       = 3'd4,
    CFG_CLICK_MIN  = 3'd5
  } bcli_cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] charge_on_level;
    logic [SAMPLE_BITS-1:0] charge_off_level;
    logic [9:0]             led_on_ticks;
    logic [7:0]             sleep_ticks;
    logic [5:0]             anim_ticks;
    logic [6:0]             click_min_ticks;
  } bcli_cfg_t;

endpackage
`default_nettype wire

FILE: src/bcli_if.sv
`default_nettype none
interface bcli_tick_if;
  import bcli_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   key_pressed;
  logic [SAMPLE_BITS-1:0] input_sample;
  logic [SAMPLE_BITS-1:0] battery_sample;
  modport source (output valid, key_pressed, input_sample, battery_sample, input ready);
  modport sink (input valid, key_pressed, input_sample, battery_sample, output ready);
endinterface

interface bcli_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] led_level;
  logic [2:0] battery_grade;
  logic       sleep_request;
  modport source (output valid, led_level, battery_grade, sleep_request, input ready);
  modport sink (input valid, led_level, battery_grade, sleep_request, output ready);
endinterface
`default_nettype wire

FILE: src/bcli_cfg_regs.sv
`default_nettype none
module bcli_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [bcli_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bcli_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bcli_pkg::bcli_cfg_t                   cfg
);
  import bcli_pkg::*;

  // Decode register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.charge_on_level  <= RST_CHARGE_ON;
      cfg.charge_off_level <= RST_CHARGE_OFF;
      cfg.led_on_ticks     <= RST_LED_ON;
      cfg.sleep_ticks      <= RST_SLEEP;
      cfg.anim_ticks       <= RST_ANIM;
      cfg.click_min_ticks  <= RST_CLICK_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHARGE_ON:  cfg.charge_on_level  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_CHARGE_OFF: cfg.charge_off_level <= cfg_data[SAMPLE_BITS-1:0];
        CFG_LED_ON:     cfg.led_on_ticks     <= cfg_data[9:0];
        CFG_SLEEP:      cfg.sleep_ticks      <= cfg_data[7:0];
        CFG_ANIM:       cfg.anim_ticks       <= cfg_data[5:0];
        CFG_CLICK_MIN:  cfg.click_min_ticks  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/bcli_core.sv
`default_nettype none
module bcli_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               adv,
  input  bcli_pkg::bcli_cfg_t                     cfg,
  input  wire logic                               key_pressed,
  input  wire logic [bcli_pkg::SAMPLE_BITS-1:0]   input_sample,
  input  wire logic [bcli_pkg::SAMPLE_BITS-1:0]   battery_sample,
  output logic [2:0]                              led_level,
  output logic [2:0]                              battery_grade,
  output logic                                    sleep_request
);
  import bcli_pkg::*;

  logic [6:0]             hold_count, hold_count_next;
  logic [5:0]             phase_count, phase_count_next;
  logic [SAMPLE_BITS-1:0] input_level, input_level_next;
  logic [2:0]             grade, grade_next;
  logic [2:0]             step_now, step_now_next;
  logic [9:0]             led_timer, led_timer_next;
  logic [7:0]             idle_timer, idle_timer_next;
  logic [5:0]             anim_timer, anim_timer_next;

  logic                   click;
  logic [CMP_W-1:0]       bat;
  logic [5:0]             anim_inc;
  logic [2:0]             step_inc;
  logic [9:0]             led_mid;

  // Grade from the battery sample, holding inside the hysteresis bands
  function automatic logic [2:0] next_grade(input logic [CMP_W-1:0] b, input logic [2:0] g);
    logic [2:0] r;
    r = g;
    if (b < BAT_G1_MAX) begin
      r = 3'd1;
    end else if (b < BAT_G2_MAX) begin
      if (g != 3'd1 || b > BAT_G2_HYS) r = 3'd2;
    end else if (b < BAT_G3_MAX) begin
      if (g != 3'd2 || b > BAT_G3_HYS) r = 3'd3;
    end else if (b < BAT_G4_MAX) begin
      if (g != 3'd3 || b > BAT_G4_HYS) r = 3'd4;
    end else if (b > BAT_G5_MIN) begin
      r = 3'd5;
    end
    return r;
  endfunction

  assign bat = CMP_W'(battery_sample);

  always_comb begin
    hold_count_next  = hold_count;
    phase_count_next = phase_count;
    input_level_next = input_level;
    grade_next       = grade;
    step_now_next    = step_now;
    led_mid          = led_timer;
    idle_timer_next  = idle_timer;
    anim_timer_next  = anim_timer;
    sleep_request    = 1'b0;
    click            = 1'b0;
    anim_inc         = anim_timer + 6'd1;
    step_inc         = step_now + 3'd1;

    // Key: count the hold, detect a click on release
    if (key_pressed) begin
      hold_count_next = (hold_count >= HOLD_MAX - 7'd1) ? HOLD_MAX : hold_count + 7'd1;
    end else begin
      click = (hold_count >= cfg.click_min_ticks);
      hold_count_next = '0;
    end
    if (click && input_level < cfg.charge_on_level) led_mid = cfg.led_on_ticks;

    // Sample by phase, then advance the phase
    if (phase_count < PHASE_INPUT_END) begin
      input_level_next = input_sample;
    end else if (phase_count >= PHASE_BAT_FIRST && phase_count < PHASE_BAT_END) begin
      grade_next = next_grade(bat, grade);
    end
    phase_count_next = (phase_count >= PHASE_LAST) ? 6'd0 : phase_count + 6'd1;

    // LED step: animate while charging, show the grade when unplugged
    if (input_level_next > cfg.charge_on_level) begin
      led_mid = cfg.led_on_ticks;
      idle_timer_next = '0;
      anim_timer_next = anim_inc;
      if (anim_inc >= cfg.anim_ticks) begin
        anim_timer_next = '0;
        step_now_next = (step_inc > STEP_TOP) ? grade_next : step_inc;
      end
    end else if (input_level_next <= cfg.charge_off_level) begin
      if (led_mid != '0) step_now_next = grade_next;
    end

    // LED timeout, then count idle ticks toward a sleep request
    if (led_mid != '0) begin
      led_timer_next = led_mid - 10'd1;
      idle_timer_next = '0;
    end else begin
      led_timer_next = led_mid;
      step_now_next = '0;
      idle_timer_next = idle_timer_next + 8'd1;
      if (idle_timer_next > cfg.sleep_ticks) begin
        sleep_request = 1'b1;
        idle_timer_next = '0;
      end
    end

    led_level     = step_now_next;
    battery_grade = grade_next;
  end

  // Commit state when the tick moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count  <= '0;
      phase_count <= '0;
      input_level <= '0;
      grade       <= '0;
      step_now    <= '0;
      led_timer   <= '0;
      idle_timer  <= '0;
      anim_timer  <= '0;
    end else if (adv) begin
      hold_count  <= hold_count_next;
      phase_count <= phase_count_next;
      input_level <= input_level_next;
      grade       <= grade_next;
      step_now    <= step_now_next;
      led_timer   <= led_timer_next;
      idle_timer  <= idle_timer_next;
      anim_timer  <= anim_timer_next;
    end
  end
endmodule
`default_nettype wire

FILE: src/battery_charge_led_indicator.sv
// Channel  Dir  Payload                                         Transfer
// tick     in   key_pressed, input_sample, battery_sample       valid & ready
// result   out  led_level, battery_grade, sleep_request         valid & ready
// cfg      in   cfg_index, cfg_data                             cfg_we
//
// One tick per cycle sustained while result.ready holds; a tick's result is
// loaded into the result register when it moves on (adv), then transfers out.
// Rate is set by the single state update between the two registers.
// Reset (rst, synchronous) clears valid flags and core state, loads defaults.
// A stalled result holds; the input register keeps taking ticks while its
// content can move into the result register in the same cycle.
`default_nettype none
module battery_charge_led_indicator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  bcli_tick_if.sink                             tick,
  bcli_result_if.source                         result,
  input  wire logic                             cfg_we,
  input  wire logic [bcli_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bcli_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bcli_pkg::*;

  bcli_cfg_t              cfg;
  logic                   in_valid;
  logic                   key_q;
  logic [SAMPLE_BITS-1:0] ins_q;
  logic [SAMPLE_BITS-1:0] bat_q;
  logic                   res_valid;
  logic                   adv;
  logic [2:0]             led_c, grade_c;
  logic                   sleep_c;

  bcli_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcli_core u_core (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .cfg            (cfg),
    .key_pressed    (key_q),
    .input_sample   (ins_q),
    .battery_sample (bat_q),
    .led_level      (led_c),
    .battery_grade  (grade_c),
    .sleep_request  (sleep_c)
  );

  // Move the held tick on when the result register is free or draining
  assign adv        = in_valid && (!res_valid || result.ready);
  assign tick.ready = !in_valid || adv;
  assign result.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (tick.ready) in_valid <= tick.valid;
      if (adv) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Capture payloads on transfer
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      key_q <= tick.key_pressed;
      ins_q <= tick.input_sample;
      bat_q <= tick.battery_sample;
    end
    if (adv) begin
      result.led_level     <= led_c;
      result.battery_grade <= grade_c;
      result.sleep_request <= sleep_c;
    end
  end
endmodule
`default_nettype wire

FILE: src/bcli_checker.sv
`default_nettype none
module bcli_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] led_level,
  input wire logic [2:0] battery_grade,
  input wire logic       sleep_request
);
  // Grade never leaves 0..5
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> battery_grade <= 3'd5)
    else $error("battery grade out of range");

  // LED step never leaves 0..5
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> led_level <= 3'd5)
    else $error("led level out of range");

  // Sleep is only requested with the LEDs dark
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && sleep_request) |-> led_level == 3'd0)
    else $error("sleep request with LEDs lit");

  // A stalled result holds valid and payload
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(led_level)
      && $stable(battery_grade) && $stable(sleep_request)))
    else $error("stalled result changed");
endmodule

bind battery_charge_led_indicator bcli_checker u_bcli_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .led_level     (result.led_level),
  .battery_grade (result.battery_grade),
  .sleep_request (result.sleep_request)
);
`default_nettype wire
